// ===== rtl/core/plsu_pkg.sv =====
// Package for the positional list store: sizes, request codes and sequencer states.
// No dependencies; used by the core and by its checker.
package plsu_pkg;

    // List capacity and entry width.
    localparam int DEPTH       = 64;
    localparam int ENTRY_BITS  = 32;
    localparam int IDX_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS    = $clog2(DEPTH + 1);

    // Port widths fixed by the interface.
    localparam int ACTION_W    = 2;
    localparam int POSITION_W  = 7;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 7;

    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [ENTRY_BITS-1:0] t_entry;

    // Request codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_STEP,
        S_INS_MOVE,
        S_FETCH,
        S_FETCHED,
        S_REM_STEP,
        S_REM_MOVE,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/positional_list_store_unit.sv =====
// Top level of the positional list store: a sequencer around one entry memory.
// Depends on plsu_pkg.
//
//  channel  | valid   | ready   | payload
//  request  | i_valid | o_ready | i_action, i_at_end, i_position, i_value
//  result   | o_valid | i_ready | o_ok, o_value_out, o_entry_count, o_is_empty
//
// One request is worked at a time; the memory has one read and one write port.
// Insert moves count-position entries up and remove moves count-position-1
// entries down; read, clear and any failing request move no entries.
// Every moved entry costs one read and one write on the memory.
// Reset clears the count and the sequencer; memory contents are not cleared.
// A result waits in the output register while the next request is accepted.
module positional_list_store_unit
    import plsu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic                  i_at_end,
    input  logic [POSITION_W-1:0] i_position,
    input  logic [VALUE_W-1:0]    i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_ok,
    output logic [VALUE_W-1:0]    o_value_out,
    output logic [COUNT_W-1:0]    o_entry_count,
    output logic                  o_is_empty
);

    localparam t_cnt DEPTH_CNT = t_cnt'(DEPTH);

    // Entry memory and its registered read data.
    t_entry mem [DEPTH];
    t_entry r_rdata;
    t_idx   rd_addr;
    logic   we;
    t_idx   wr_addr;
    t_entry wr_data;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_idx   r_idx, n_idx;
    t_idx   r_pos, n_pos;
    t_entry r_data, n_data;
    logic   r_remove, n_remove;
    logic   r_res_ok, n_res_ok;
    t_entry r_res_val, n_res_val;

    logic               r_o_valid, n_o_valid;
    logic               r_o_ok, n_o_ok;
    logic [VALUE_W-1:0] r_o_val, n_o_val;
    t_cnt               r_o_cnt, n_o_cnt;

    logic [POSITION_W-1:0] ins_pos;
    logic [POSITION_W-1:0] rem_pos;
    t_cnt                  idx_next;
    logic                  accept;

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // Work and result payload registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_data    <= n_data;
        r_remove  <= n_remove;
        r_res_ok  <= n_res_ok;
        r_res_val <= n_res_val;
        r_o_ok    <= n_o_ok;
        r_o_val   <= n_o_val;
        r_o_cnt   <= n_o_cnt;
    end

    assign accept   = i_valid && o_ready;
    assign ins_pos  = i_at_end ? POSITION_W'(r_count) : i_position;
    assign rem_pos  = i_at_end ? POSITION_W'(r_count - t_cnt'(1)) : i_position;
    assign idx_next = t_cnt'(r_idx) + t_cnt'(1);

    // Sequencer: next state, memory control and result capture.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_data    = r_data;
        n_remove  = r_remove;
        n_res_ok  = r_res_ok;
        n_res_val = r_res_val;
        n_o_valid = r_o_valid;
        n_o_ok    = r_o_ok;
        n_o_val   = r_o_val;
        n_o_cnt   = r_o_cnt;
        rd_addr   = r_idx;
        we        = 1'b0;
        wr_addr   = r_idx;
        wr_data   = r_rdata;
        o_ready   = (r_state == S_IDLE);

        // The output word leaves when the consumer takes it.
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_ok  = 1'b0;
                    n_res_val = '0;
                    n_remove  = 1'b0;
                    n_data    = i_value[ENTRY_BITS-1:0];
                    n_state   = S_DONE;
                    case (t_action'(i_action))
                        ACT_INSERT: begin
                            if (r_count < DEPTH_CNT && ins_pos <= POSITION_W'(r_count)) begin
                                n_pos   = ins_pos[IDX_BITS-1:0];
                                n_idx   = r_count[IDX_BITS-1:0];
                                n_state = S_INS_STEP;
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_count != '0 && rem_pos < POSITION_W'(r_count)) begin
                                n_idx    = rem_pos[IDX_BITS-1:0];
                                n_remove = 1'b1;
                                n_state  = S_FETCH;
                            end
                        end
                        ACT_READ: begin
                            if (i_position < POSITION_W'(r_count)) begin
                                n_idx   = i_position[IDX_BITS-1:0];
                                n_state = S_FETCH;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count  = '0;
                            n_res_ok = 1'b1;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Insert: move entries up one at a time from the tail down.
            S_INS_STEP: begin
                if (r_idx == r_pos) begin
                    we       = 1'b1;
                    wr_data  = r_data;
                    n_count  = r_count + t_cnt'(1);
                    n_res_ok = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    rd_addr = r_idx - t_idx'(1);
                    n_state = S_INS_MOVE;
                end
            end
            S_INS_MOVE: begin
                we      = 1'b1;
                n_idx   = r_idx - t_idx'(1);
                n_state = S_INS_STEP;
            end

            // Read and remove: fetch the addressed entry.
            S_FETCH: begin
                n_state = S_FETCHED;
            end
            S_FETCHED: begin
                n_res_val = r_rdata;
                n_res_ok  = 1'b1;
                n_state   = r_remove ? S_REM_STEP : S_DONE;
            end

            // Remove: close the gap by moving later entries down.
            S_REM_STEP: begin
                if (idx_next >= r_count) begin
                    n_count = r_count - t_cnt'(1);
                    n_state = S_DONE;
                end else begin
                    rd_addr = idx_next[IDX_BITS-1:0];
                    n_state = S_REM_MOVE;
                end
            end
            S_REM_MOVE: begin
                we      = 1'b1;
                n_idx   = idx_next[IDX_BITS-1:0];
                n_state = S_REM_STEP;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_ok    = r_res_ok;
                    n_o_val   = VALUE_W'(r_res_val);
                    n_o_cnt   = r_count;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid       = r_o_valid;
    assign o_ok          = r_o_ok;
    assign o_value_out   = r_o_val;
    assign o_entry_count = COUNT_W'(r_o_cnt);
    assign o_is_empty    = (r_o_cnt == '0);

endmodule

// ===== rtl/core/plsu_checker.sv =====
// Port-level checker for the positional list store, bound to the top level.
// Depends on plsu_pkg.
module plsu_checker
    import plsu_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic                  o_ok,
    input logic [VALUE_W-1:0]    o_value_out,
    input logic [COUNT_W-1:0]    o_entry_count,
    input logic                  o_is_empty
);

    // A stalled result word holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value_out) && $stable(o_entry_count))
        else $error("result word changed while stalled");

    // The empty flag agrees with the count.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    // The count never exceeds the capacity.
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= COUNT_W'(DEPTH)))
        else $error("count above capacity");

    // A failed request returns no data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> (o_value_out == '0))
        else $error("failed request returned data");

endmodule

bind positional_list_store_unit plsu_checker u_plsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_ok          (o_ok),
    .o_value_out   (o_value_out),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty)
);
